// ===== sv/dput_pkg.sv =====
// Shared types and constants of the display page update table.
package dput_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] CMD_ADD_PAGE = 2'd0;
  localparam logic [1:0] CMD_ADD_COLUMN = 2'd1;
  localparam logic [1:0] CMD_COMMIT = 2'd2;

  localparam logic [1:0] REG_MAX_COLUMN = 2'd0;
  localparam logic [1:0] REG_MAX_PAGE_ROW = 2'd1;
  localparam logic [1:0] REG_MAX_PIXEL_ROW = 2'd2;

  localparam logic [7:0] RST_MAX_COLUMN = 8'd159;
  localparam logic [7:0] RST_MAX_PAGE_ROW = 8'd100;
  localparam logic [9:0] RST_MAX_PIXEL_ROW = 10'd104;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] x_pos;
    logic [9:0] row;
    logic [7:0] bits;
  } req_t;

  typedef struct packed {
    logic [7:0] out_x;
    logic [7:0] out_row;
    logic [7:0] out_bits;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [7:0] max_column;
    logic [7:0] max_page_row;
    logic [9:0] max_pixel_row;
  } cfg_t;

  // A slot below the fill count is live unless its deleted flag is set.
  typedef struct packed {
    logic       del;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] h;
  } slot_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] h;
  } page_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PD_RD,
    ST_PD_CK,
    ST_PE_RD,
    ST_PE_CK,
    ST_INS,
    ST_MI_RD,
    ST_MI_CK,
    ST_MJ_RD,
    ST_MJ_CK,
    ST_MI_WR,
    ST_EE_RD,
    ST_EE_CK,
    ST_ED_RD,
    ST_ED_CK,
    ST_FLUSH
  } state_e;

endpackage

// ===== sv/dput_ram.sv =====
// Single-port synchronous RAM with registered read data.
module dput_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 25
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dput_cfg.sv =====
// APB register file holding the range limits.
module dput_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output dput_pkg::cfg_t    cfg_o
);

  dput_pkg::cfg_t cfg_q, cfg_d;
  logic           wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (paddr[3:2])
        dput_pkg::REG_MAX_COLUMN: cfg_d.max_column = pwdata[7:0];
        dput_pkg::REG_MAX_PAGE_ROW: cfg_d.max_page_row = pwdata[7:0];
        dput_pkg::REG_MAX_PIXEL_ROW: cfg_d.max_pixel_row = pwdata[9:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dput_pkg::REG_MAX_COLUMN: prdata = {24'd0, cfg_q.max_column};
      dput_pkg::REG_MAX_PAGE_ROW: prdata = {24'd0, cfg_q.max_page_row};
      dput_pkg::REG_MAX_PIXEL_ROW: prdata = {22'd0, cfg_q.max_pixel_row};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_column <= dput_pkg::RST_MAX_COLUMN;
      cfg_q.max_page_row <= dput_pkg::RST_MAX_PAGE_ROW;
      cfg_q.max_pixel_row <= dput_pkg::RST_MAX_PIXEL_ROW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/display_page_update_table.sv =====
// Top level of the display page update table: sequencer over two slot memories.
// One request is processed at a time; in_ready_o is high only while the sequencer is idle.
// Each visited slot has an RD state (address) and a CK state (registered read data) in
// the single-port slot memories. An add_page scans the used slots of the draw and erase
// tables; an add_column repeats the scans for its second page, if any. A commit is led by
// the pairwise merge of the draw table and also waits while the output side stalls. The
// final page write of a commit carries last set. Fill counts mark used slots, so reset
// needs no clearing pass.
module display_page_update_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dput_pkg::req_t      in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dput_pkg::rsp_t      out_rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CW = dput_pkg::CNT_W;
  localparam int unsigned IW = dput_pkg::IDX_W;
  localparam int unsigned SW = $bits(dput_pkg::slot_t);
  localparam logic [CW-1:0] DEPTH_C = CW'(dput_pkg::TABLE_DEPTH);

  dput_pkg::cfg_t   cfg;
  dput_pkg::state_e state_q, state_d;

  logic [CW-1:0] idx_q, idx_d, jdx_q, jdx_d, k_q, k_d;
  logic [CW-1:0] dcnt_q, dcnt_d, ecnt_q, ecnt_d;
  dput_pkg::page_t page_q, page_d, pg2_q, pg2_d;
  logic          pg2_v_q, pg2_v_d;
  logic          free_v_q, free_v_d, hit_q, hit_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic [7:0]    ix_q, ix_d, iy_q, iy_d, acc_q, acc_d;
  dput_pkg::rsp_t out_q, out_d, pend_q, pend_d;
  logic          out_v_q, out_v_d, pend_v_q, pend_v_d;

  logic          d_we, d_re, e_we, e_re;
  logic [IW-1:0] d_addr, e_addr;
  dput_pkg::slot_t d_wdata, e_wdata, d_rd, e_rd;
  logic [SW-1:0] d_rdata, e_rdata;

  // Request decode.
  logic [15:0]   shifted;
  logic [8:0]    p1;
  logic          ok0, ok1;
  dput_pkg::page_t cp0, cp1;
  logic          out_free, can_emit;
  dput_pkg::rsp_t emit_v;
  logic          do_emit;

  dput_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dput_ram #(.DEPTH(dput_pkg::TABLE_DEPTH), .WIDTH(SW)) u_draw (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .re_i    (d_re),
    .addr_i  (d_addr),
    .wdata_i (d_wdata),
    .rdata_o (d_rdata)
  );

  dput_ram #(.DEPTH(dput_pkg::TABLE_DEPTH), .WIDTH(SW)) u_erase (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .re_i    (e_re),
    .addr_i  (e_addr),
    .wdata_i (e_wdata),
    .rdata_o (e_rdata)
  );

  assign d_rd = dput_pkg::slot_t'(d_rdata);
  assign e_rd = dput_pkg::slot_t'(e_rdata);
  assign in_ready_o = (state_q == dput_pkg::ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_rsp_o = out_q;
  assign out_free = !out_v_q || out_ready_i;
  assign can_emit = !pend_v_q || out_free;

  always_comb begin
    shifted = 16'({8'd0, in_req_i.bits} << {in_req_i.row[1:0], 1'b0});
    p1 = {1'b0, in_req_i.row[9:2]} + 9'd1;
    cp0 = '0;
    cp1 = '0;
    ok0 = 1'b0;
    ok1 = 1'b0;
    if (in_req_i.cmd == dput_pkg::CMD_ADD_PAGE) begin
      cp0 = '{x: in_req_i.x_pos, y: in_req_i.row[7:0], h: in_req_i.bits};
      ok0 = (in_req_i.x_pos <= cfg.max_column) &&
            (in_req_i.row <= {2'd0, cfg.max_page_row});
    end else if (in_req_i.cmd == dput_pkg::CMD_ADD_COLUMN) begin
      cp0 = '{x: in_req_i.x_pos, y: in_req_i.row[9:2], h: shifted[7:0]};
      cp1 = '{x: in_req_i.x_pos, y: p1[7:0], h: shifted[15:8]};
      if ((in_req_i.x_pos <= cfg.max_column) && (in_req_i.row <= cfg.max_pixel_row)) begin
        ok0 = (in_req_i.row[9:2] <= cfg.max_page_row);
        ok1 = (in_req_i.row[1:0] != 2'd0) && (p1 <= {1'b0, cfg.max_page_row});
      end
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    jdx_d = jdx_q;
    k_d = k_q;
    dcnt_d = dcnt_q;
    ecnt_d = ecnt_q;
    page_d = page_q;
    pg2_d = pg2_q;
    pg2_v_d = pg2_v_q;
    free_v_d = free_v_q;
    free_idx_d = free_idx_q;
    hit_d = hit_q;
    ix_d = ix_q;
    iy_d = iy_q;
    acc_d = acc_q;
    out_d = out_q;
    out_v_d = out_v_q && !out_ready_i;
    pend_d = pend_q;
    pend_v_d = pend_v_q;
    d_we = 1'b0;
    d_re = 1'b0;
    d_addr = idx_q[IW-1:0];
    d_wdata = '0;
    e_we = 1'b0;
    e_re = 1'b0;
    e_addr = idx_q[IW-1:0];
    e_wdata = '0;
    emit_v = '0;
    do_emit = 1'b0;

    case (state_q)
      dput_pkg::ST_IDLE: begin
        idx_d = '0;
        free_v_d = 1'b0;
        if (in_valid_i) begin
          if (in_req_i.cmd == dput_pkg::CMD_COMMIT) begin
            state_d = dput_pkg::ST_MI_RD;
          end else if (ok0 || ok1) begin
            page_d = ok0 ? cp0 : cp1;
            pg2_d = cp1;
            pg2_v_d = ok0 && ok1;
            state_d = dput_pkg::ST_PD_RD;
          end
        end
      end
      dput_pkg::ST_PD_RD: begin
        if (idx_q < dcnt_q) begin
          d_re = 1'b1;
          state_d = dput_pkg::ST_PD_CK;
        end else begin
          idx_d = '0;
          hit_d = 1'b0;
          state_d = dput_pkg::ST_PE_RD;
        end
      end
      dput_pkg::ST_PD_CK: begin
        idx_d = idx_q + CW'(1);
        state_d = dput_pkg::ST_PD_RD;
        if (!d_rd.del && d_rd.x == page_q.x && d_rd.y == page_q.y && d_rd.h == page_q.h) begin
          // Already queued for drawing: this page is finished.
          idx_d = '0;
          free_v_d = 1'b0;
          if (pg2_v_q) begin
            page_d = pg2_q;
            pg2_v_d = 1'b0;
          end else begin
            state_d = dput_pkg::ST_IDLE;
          end
        end else if (d_rd.del && !free_v_q) begin
          free_v_d = 1'b1;
          free_idx_d = idx_q[IW-1:0];
        end
      end
      dput_pkg::ST_PE_RD: begin
        if (idx_q < ecnt_q) begin
          e_re = 1'b1;
          state_d = dput_pkg::ST_PE_CK;
        end else if (hit_q) begin
          idx_d = '0;
          free_v_d = 1'b0;
          if (pg2_v_q) begin
            page_d = pg2_q;
            pg2_v_d = 1'b0;
            state_d = dput_pkg::ST_PD_RD;
          end else begin
            state_d = dput_pkg::ST_IDLE;
          end
        end else begin
          state_d = dput_pkg::ST_INS;
        end
      end
      dput_pkg::ST_PE_CK: begin
        // A page that is still on screen cancels its pending erase.
        if (!e_rd.del && e_rd.x == page_q.x && e_rd.y == page_q.y && e_rd.h == page_q.h) begin
          e_we = 1'b1;
          e_wdata = e_rd;
          e_wdata.del = 1'b1;
          hit_d = 1'b1;
        end
        idx_d = idx_q + CW'(1);
        state_d = dput_pkg::ST_PE_RD;
      end
      dput_pkg::ST_INS: begin
        d_wdata = '{del: 1'b0, x: page_q.x, y: page_q.y, h: page_q.h};
        if (free_v_q) begin
          d_we = 1'b1;
          d_addr = free_idx_q;
        end else if (dcnt_q < DEPTH_C) begin
          d_we = 1'b1;
          d_addr = dcnt_q[IW-1:0];
          dcnt_d = dcnt_q + CW'(1);
        end
        idx_d = '0;
        free_v_d = 1'b0;
        if (pg2_v_q) begin
          page_d = pg2_q;
          pg2_v_d = 1'b0;
          state_d = dput_pkg::ST_PD_RD;
        end else begin
          state_d = dput_pkg::ST_IDLE;
        end
      end
      dput_pkg::ST_MI_RD: begin
        if (idx_q < dcnt_q) begin
          d_re = 1'b1;
          state_d = dput_pkg::ST_MI_CK;
        end else begin
          idx_d = '0;
          state_d = dput_pkg::ST_EE_RD;
        end
      end
      dput_pkg::ST_MI_CK: begin
        if (d_rd.del) begin
          idx_d = idx_q + CW'(1);
          state_d = dput_pkg::ST_MI_RD;
        end else begin
          ix_d = d_rd.x;
          iy_d = d_rd.y;
          acc_d = d_rd.h;
          jdx_d = idx_q + CW'(1);
          state_d = dput_pkg::ST_MJ_RD;
        end
      end
      dput_pkg::ST_MJ_RD: begin
        d_addr = jdx_q[IW-1:0];
        if (jdx_q < dcnt_q) begin
          d_re = 1'b1;
          state_d = dput_pkg::ST_MJ_CK;
        end else begin
          state_d = dput_pkg::ST_MI_WR;
        end
      end
      dput_pkg::ST_MJ_CK: begin
        d_addr = jdx_q[IW-1:0];
        if (!d_rd.del && d_rd.x == ix_q && d_rd.y == iy_q) begin
          acc_d = acc_q | d_rd.h;
          d_we = 1'b1;
          d_wdata = d_rd;
          d_wdata.del = 1'b1;
        end
        jdx_d = jdx_q + CW'(1);
        state_d = dput_pkg::ST_MJ_RD;
      end
      dput_pkg::ST_MI_WR: begin
        d_we = 1'b1;
        d_wdata = '{del: 1'b0, x: ix_q, y: iy_q, h: acc_q};
        idx_d = idx_q + CW'(1);
        state_d = dput_pkg::ST_MI_RD;
      end
      dput_pkg::ST_EE_RD: begin
        if (idx_q < ecnt_q) begin
          e_re = 1'b1;
          state_d = dput_pkg::ST_EE_CK;
        end else begin
          idx_d = '0;
          k_d = '0;
          state_d = dput_pkg::ST_ED_RD;
        end
      end
      dput_pkg::ST_EE_CK: begin
        emit_v = '{out_x: e_rd.x, out_row: e_rd.y, out_bits: 8'd0, last: 1'b0};
        if (e_rd.del) begin
          idx_d = idx_q + CW'(1);
          state_d = dput_pkg::ST_EE_RD;
        end else if (can_emit) begin
          do_emit = 1'b1;
          idx_d = idx_q + CW'(1);
          state_d = dput_pkg::ST_EE_RD;
        end
      end
      dput_pkg::ST_ED_RD: begin
        if (idx_q < dcnt_q) begin
          d_re = 1'b1;
          state_d = dput_pkg::ST_ED_CK;
        end else begin
          ecnt_d = k_q;
          dcnt_d = '0;
          state_d = dput_pkg::ST_FLUSH;
        end
      end
      dput_pkg::ST_ED_CK: begin
        emit_v = '{out_x: d_rd.x, out_row: d_rd.y, out_bits: d_rd.h, last: 1'b0};
        e_addr = k_q[IW-1:0];
        e_wdata = d_rd;
        if (d_rd.del) begin
          idx_d = idx_q + CW'(1);
          state_d = dput_pkg::ST_ED_RD;
        end else if (can_emit) begin
          do_emit = 1'b1;
          e_we = 1'b1;
          k_d = k_q + CW'(1);
          idx_d = idx_q + CW'(1);
          state_d = dput_pkg::ST_ED_RD;
        end
      end
      dput_pkg::ST_FLUSH: begin
        // The held write is the final one of the commit.
        if (!pend_v_q) begin
          state_d = dput_pkg::ST_IDLE;
        end else if (out_free) begin
          out_d = pend_q;
          out_d.last = 1'b1;
          out_v_d = 1'b1;
          pend_v_d = 1'b0;
          state_d = dput_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dput_pkg::ST_IDLE;
      end
    endcase

    // One write is held back so that the last one can be flagged.
    if (do_emit) begin
      if (pend_v_q) begin
        out_d = pend_q;
        out_v_d = 1'b1;
      end
      pend_d = emit_v;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dput_pkg::ST_IDLE;
      idx_q <= '0;
      jdx_q <= '0;
      k_q <= '0;
      dcnt_q <= '0;
      ecnt_q <= '0;
      pg2_v_q <= 1'b0;
      free_v_q <= 1'b0;
      hit_q <= 1'b0;
      out_v_q <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      jdx_q <= jdx_d;
      k_q <= k_d;
      dcnt_q <= dcnt_d;
      ecnt_q <= ecnt_d;
      pg2_v_q <= pg2_v_d;
      free_v_q <= free_v_d;
      hit_q <= hit_d;
      out_v_q <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    pg2_q <= pg2_d;
    free_idx_q <= free_idx_d;
    ix_q <= ix_d;
    iy_q <= iy_d;
    acc_q <= acc_d;
    out_q <= out_d;
    pend_q <= pend_d;
  end

endmodule
